[src/fppjg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fppjg_pkg: shared types and constants of the framed position parser
// Widths of the channel payloads, character codes, register indexes and
// reset values used by the interfaces and the top level.
// ----------------------------------------------------------------------------
package fppjg_pkg;

	localparam int BYTE_W   = 8;
	localparam int POS_W    = 16;
	localparam int IDX_W    = 10;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int LIMIT_W  = 16;
	localparam int HALO_W   = 8;
	localparam int MAG_W    = 16;

	typedef logic [BYTE_W-1:0]     byte_t;
	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [IDX_W-1:0]      led_idx_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [LIMIT_W-1:0]    limit_t;
	typedef logic [HALO_W-1:0]     halo_t;
	typedef logic [MAG_W-1:0]      mag_t;

	// Register indexes on the configuration port.
	localparam cfg_idx_t REG_JUMP_LIMIT = 8'd0;
	localparam cfg_idx_t REG_HALO_HALF  = 8'd1;

	// Character codes.
	localparam byte_t CH_OPEN  = 8'h73;  // 's'
	localparam byte_t CH_CLOSE = 8'h65;  // 'e'
	localparam byte_t CH_SEP   = 8'h3B;  // ';'
	localparam byte_t CH_PLUS  = 8'h2B;
	localparam byte_t CH_MINUS = 8'h2D;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_TAB   = 8'h09;
	localparam byte_t CH_CR    = 8'h0D;
	localparam byte_t CH_ZERO  = 8'h30;
	localparam byte_t CH_NINE  = 8'h39;

	// Number decoder phases.
	localparam logic [1:0] PH_SKIP   = 2'd0;
	localparam logic [1:0] PH_SIGN   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_STOP   = 2'd3;

	// Saturation bounds of the decoded value.
	localparam mag_t MAG_CAP = 16'd32768;
	localparam mag_t POS_MAX = 16'd32767;

	// Reset values.
	localparam limit_t JUMP_LIMIT_RST = 16'd40;
	localparam halo_t  HALO_HALF_RST  = 8'd15;
	localparam pos_t   HELD_POS_RST   = 16'sd10;

endpackage

[src/fppjg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fppjg_if: channel interfaces of the framed position parser
// Byte input channel, result channel and configuration write channel, each
// with valid and ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface fppjg_byte_if;
	logic             valid;
	logic             ready;
	fppjg_pkg::byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fppjg_result_if;
	logic                valid;
	logic                ready;
	fppjg_pkg::pos_t     position;
	logic                accepted;
	fppjg_pkg::led_idx_t window_first;
	fppjg_pkg::led_idx_t window_last;
	logic                window_empty;

	modport source (output valid, output position, output accepted, output window_first,
		output window_last, output window_empty, input ready);
	modport sink   (input valid, input position, input accepted, input window_first,
		input window_last, input window_empty, output ready);
endinterface

interface fppjg_cfg_if;
	logic                 valid;
	logic                 ready;
	fppjg_pkg::cfg_idx_t  index;
	fppjg_pkg::cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[src/framed_position_parser_with_jump_gate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_position_parser_with_jump_gate: packet position decoder and gate
// Parses 's'-framed, ';'-separated packets byte by byte, decodes the second
// field as a saturating decimal, gates it against the held position and
// reports the held position with its clipped LED window.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on the rx channel, one item per accepted handshake.
// Only the closing 'e' of a packet produces an item on the res channel; all
// other bytes just update the parser state. The cfg channel writes the jump
// limit (index 0) and the halo half width (index 1); it is always ready and
// should only be written while the block is idle. Writes to other indexes
// are ignored.
// The block is a three-register pipeline: an input register, the parser
// and jump gate stage, and the window clipping stage that feeds the result
// register. A result moves on from the parser stage to the result register.
// Throughput is one byte per cycle unless the result side stalls; the parser
// state feeds back through its own register, so bytes can follow back to back.
// Reset clears the pipeline, closes any open packet, restores the default
// register values and sets the held position to ten.
// When the receiver stalls, results wait in the pipeline; rx stays ready
// as long as some stage is free, and only deasserts once all are full.
// ----------------------------------------------------------------------------
module framed_position_parser_with_jump_gate #(
	parameter int STRIP_LENGTH = 150
) (
	input  logic            clk,
	input  logic            arst_n,
	fppjg_cfg_if.sink       cfg,
	fppjg_byte_if.sink      rx,
	fppjg_result_if.source  res
);

	// Index of the last LED on the strip, in the width of the window math.
	localparam logic signed [17:0] LAST_LED = 18'(STRIP_LENGTH - 1);

	// Configuration registers.
	fppjg_pkg::limit_t jump_limit_q;
	fppjg_pkg::halo_t  halo_half_q;

	// Parser and gate state.
	logic               in_packet_q;
	logic [1:0]         sep_count_q;
	logic [1:0]         phase_q;
	logic               negative_q;
	fppjg_pkg::mag_t    magnitude_q;
	fppjg_pkg::pos_t    held_pos_q;

	// Pipeline registers.
	logic               valid_s1;
	fppjg_pkg::byte_t   byte_s1;
	logic               valid_s2;
	fppjg_pkg::pos_t    pos_s2;
	logic               acc_s2;
	logic               valid_s3;
	fppjg_pkg::pos_t    pos_s3;
	logic               acc_s3;
	fppjg_pkg::led_idx_t first_s3;
	fppjg_pkg::led_idx_t last_s3;
	logic               empty_s3;

	// Stage handshakes: a stage may load when it is empty or its contents move on.
	logic ready_s1, ready_s2, ready_s3, fire_s1;

	assign ready_s3 = !valid_s3 || res.ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign fire_s1  = valid_s1 && ready_s2;

	assign rx.ready  = ready_s1;
	assign cfg.ready = 1'b1;

	// ------------------------------------------------------------------
	// Configuration writes.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_limit_q <= fppjg_pkg::JUMP_LIMIT_RST;
			halo_half_q  <= fppjg_pkg::HALO_HALF_RST;
		end else if (cfg.valid) begin
			if (cfg.index == fppjg_pkg::REG_JUMP_LIMIT) begin
				jump_limit_q <= cfg.data[fppjg_pkg::LIMIT_W-1:0];
			end else if (cfg.index == fppjg_pkg::REG_HALO_HALF) begin
				halo_half_q <= cfg.data[fppjg_pkg::HALO_W-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Input register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// ------------------------------------------------------------------
	// Parser, number decoder and jump gate.
	// ------------------------------------------------------------------
	logic               in_packet_d;
	logic [1:0]         sep_count_d;
	logic [1:0]         phase_d;
	logic               negative_d;
	fppjg_pkg::mag_t    magnitude_d;
	fppjg_pkg::pos_t    held_pos_d;
	logic               emit;
	logic               accept;
	logic               is_digit;
	logic               is_blank;
	logic [18:0]        mag_next;
	fppjg_pkg::mag_t    mag_digit;
	logic [16:0]        neg_value;
	fppjg_pkg::pos_t    value;
	logic signed [16:0] diff;
	logic [16:0]        abs_diff;

	always_comb begin
		is_digit = byte_s1 inside {[fppjg_pkg::CH_ZERO:fppjg_pkg::CH_NINE]};
		is_blank = byte_s1 inside {fppjg_pkg::CH_SPACE, [fppjg_pkg::CH_TAB:fppjg_pkg::CH_CR]};

		// Magnitude times ten plus the new digit, saturated at the cap.
		mag_next  = (19'(magnitude_q) << 3) + (19'(magnitude_q) << 1) + 19'(byte_s1[3:0]);
		mag_digit = (mag_next > 19'(fppjg_pkg::MAG_CAP)) ? fppjg_pkg::MAG_CAP
			: mag_next[fppjg_pkg::MAG_W-1:0];

		// Decoded value: a negative magnitude always fits, a positive one clamps.
		neg_value = 17'd0 - {1'b0, magnitude_q};
		if (negative_q) begin
			value = neg_value[fppjg_pkg::POS_W-1:0];
		end else if (magnitude_q > fppjg_pkg::POS_MAX) begin
			value = fppjg_pkg::POS_MAX;
		end else begin
			value = magnitude_q;
		end

		diff     = 17'(value) - 17'(held_pos_q);
		abs_diff = diff[16] ? (17'd0 - 17'(diff)) : 17'(diff);
		accept   = abs_diff < {1'b0, jump_limit_q};

		in_packet_d = in_packet_q;
		sep_count_d = sep_count_q;
		phase_d     = phase_q;
		negative_d  = negative_q;
		magnitude_d = magnitude_q;
		held_pos_d  = held_pos_q;
		emit        = 1'b0;

		if (!in_packet_q) begin
			// Outside a packet only the opening byte matters.
			if (byte_s1 == fppjg_pkg::CH_OPEN) begin
				in_packet_d = 1'b1;
				sep_count_d = 2'd0;
				phase_d     = fppjg_pkg::PH_SKIP;
				negative_d  = 1'b0;
				magnitude_d = '0;
			end
		end else if (byte_s1 != fppjg_pkg::CH_CLOSE) begin
			if (byte_s1 == fppjg_pkg::CH_SEP) begin
				if (sep_count_q != 2'd2) begin
					sep_count_d = sep_count_q + 2'd1;
				end
			end else if (sep_count_q == 2'd1) begin
				// Bytes of the second field feed the decimal decoder.
				case (phase_q)
					fppjg_pkg::PH_SKIP: begin
						if (is_blank) begin
							phase_d = fppjg_pkg::PH_SKIP;
						end else if (byte_s1 == fppjg_pkg::CH_PLUS
							|| byte_s1 == fppjg_pkg::CH_MINUS) begin
							negative_d = (byte_s1 == fppjg_pkg::CH_MINUS);
							phase_d    = fppjg_pkg::PH_SIGN;
						end else if (is_digit) begin
							magnitude_d = mag_digit;
							phase_d     = fppjg_pkg::PH_DIGITS;
						end else begin
							phase_d = fppjg_pkg::PH_STOP;
						end
					end
					fppjg_pkg::PH_SIGN, fppjg_pkg::PH_DIGITS: begin
						if (is_digit) begin
							magnitude_d = mag_digit;
							phase_d     = fppjg_pkg::PH_DIGITS;
						end else begin
							phase_d = fppjg_pkg::PH_STOP;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end else begin
			// Closing byte: gate the value, end the packet and report.
			emit        = 1'b1;
			in_packet_d = 1'b0;
			sep_count_d = 2'd0;
			phase_d     = fppjg_pkg::PH_SKIP;
			negative_d  = 1'b0;
			magnitude_d = '0;
			if (accept) begin
				held_pos_d = value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			sep_count_q <= 2'd0;
			phase_q     <= fppjg_pkg::PH_SKIP;
			negative_q  <= 1'b0;
			magnitude_q <= '0;
			held_pos_q  <= fppjg_pkg::HELD_POS_RST;
			valid_s2    <= 1'b0;
		end else begin
			if (fire_s1) begin
				in_packet_q <= in_packet_d;
				sep_count_q <= sep_count_d;
				phase_q     <= phase_d;
				negative_q  <= negative_d;
				magnitude_q <= magnitude_d;
				held_pos_q  <= held_pos_d;
			end
			if (ready_s2) begin
				valid_s2 <= fire_s1 && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			pos_s2 <= held_pos_d;
			acc_s2 <= accept;
		end
	end

	// ------------------------------------------------------------------
	// Window clipping and result register.
	// ------------------------------------------------------------------
	logic signed [17:0] halo_ext;
	logic signed [17:0] first_raw;
	logic signed [17:0] last_raw;
	logic signed [17:0] first_clip;
	logic signed [17:0] last_clip;
	logic               empty;

	always_comb begin
		halo_ext   = $signed({10'd0, halo_half_q});
		first_raw  = 18'(pos_s2) - halo_ext;
		last_raw   = 18'(pos_s2) + halo_ext - 18'sd1;
		first_clip = (first_raw < 18'sd0) ? 18'sd0 : first_raw;
		last_clip  = (last_raw > LAST_LED) ? LAST_LED : last_raw;
		empty      = (halo_half_q == '0) || (first_clip > last_clip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			pos_s3   <= pos_s2;
			acc_s3   <= acc_s2;
			empty_s3 <= empty;
			first_s3 <= empty ? '0 : first_clip[fppjg_pkg::IDX_W-1:0];
			last_s3  <= empty ? '0 : last_clip[fppjg_pkg::IDX_W-1:0];
		end
	end

	assign res.valid        = valid_s3;
	assign res.position     = pos_s3;
	assign res.accepted     = acc_s3;
	assign res.window_first = first_s3;
	assign res.window_last  = last_s3;
	assign res.window_empty = empty_s3;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the framed position parser
// Feeds directed and random byte streams into the parser, with random gaps
// on the byte side and random stalls on the result side, and checks every
// result item against a cycle-free model of the packet decoder, the jump
// gate and the LED window clipping. Register settings are changed between
// phases while the block is idle, including the extreme values.
// ----------------------------------------------------------------------------
module testbench;

	localparam int STRIP   = 150;
	localparam int LATENCY = 2;

	// A register index that the block must ignore.
	localparam fppjg_pkg::cfg_idx_t REG_UNUSED = 8'd2;

	// One expected result item.
	typedef struct {
		fppjg_pkg::pos_t     position;
		logic                accepted;
		fppjg_pkg::led_idx_t first;
		fppjg_pkg::led_idx_t last;
		logic                empty;
	} window_report_t;

	logic clk;
	logic arst_n;

	fppjg_byte_if   rx_ch ();
	fppjg_result_if res_ch ();
	fppjg_cfg_if    cfg_ch ();

	framed_position_parser_with_jump_gate #(
		.STRIP_LENGTH(STRIP)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	// Results still owed by the block, oldest first.
	window_report_t reports_due[$];

	// Our own copy of the parser state and the two registers, advanced by
	// every byte that the block accepts.
	logic               pkt_open  = 1'b0;
	logic [1:0]         sep_seen  = 2'd0;
	logic [1:0]         num_phase = fppjg_pkg::PH_SKIP;
	logic               num_neg   = 1'b0;
	int                 num_mag   = 0;
	fppjg_pkg::pos_t    held_pos  = fppjg_pkg::HELD_POS_RST;
	fppjg_pkg::limit_t  jump_lim  = fppjg_pkg::JUMP_LIMIT_RST;
	fppjg_pkg::halo_t   halo      = fppjg_pkg::HALO_HALF_RST;

	// Shared controls of the two random idlers and the long receiver stall.
	logic gaps_on      = 1'b1;
	int   hold_request = 0;

	// Run statistics.
	int errors        = 0;
	int live_bytes    = 0;
	int reports_seen  = 0;
	int accept_count  = 0;
	int reg_writes    = 0;
	int rx_stall_cycs = 0;

	// ------------------------------------------------------------------
	// Clock and the hard limit on the run.
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("%0t: timeout, %0d results still pending", $time, reports_due.size());
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor. The number decoder behaves like atol on the field after
	// the first separator, with the magnitude clamped at 32768 so the value
	// saturates to the 16-bit signed range.
	// ------------------------------------------------------------------
	task automatic clear_number();
		sep_seen  = 2'd0;
		num_phase = fppjg_pkg::PH_SKIP;
		num_neg   = 1'b0;
		num_mag   = 0;
	endtask

	task automatic decode_char(input fppjg_pkg::byte_t c);
		logic digit;
		logic blank;
		digit = (c >= fppjg_pkg::CH_ZERO) && (c <= fppjg_pkg::CH_NINE);
		blank = (c == fppjg_pkg::CH_SPACE)
			|| ((c >= fppjg_pkg::CH_TAB) && (c <= fppjg_pkg::CH_CR));
		if (num_phase == fppjg_pkg::PH_SKIP && blank) begin
			return;
		end
		if (num_phase == fppjg_pkg::PH_SKIP
			&& (c == fppjg_pkg::CH_PLUS || c == fppjg_pkg::CH_MINUS)) begin
			num_neg   = (c == fppjg_pkg::CH_MINUS);
			num_phase = fppjg_pkg::PH_SIGN;
		end else if (num_phase != fppjg_pkg::PH_STOP && digit) begin
			num_mag = num_mag * 10 + int'(c - fppjg_pkg::CH_ZERO);
			if (num_mag > int'(fppjg_pkg::MAG_CAP))
				num_mag = int'(fppjg_pkg::MAG_CAP);
			num_phase = fppjg_pkg::PH_DIGITS;
		end else begin
			num_phase = fppjg_pkg::PH_STOP;
		end
	endtask

	task automatic track_byte(input fppjg_pkg::byte_t c);
		window_report_t r;
		int val, gap, first, last, h;
		logic ok;
		if (pkt_open || c == fppjg_pkg::CH_OPEN)
			live_bytes++;
		if (!pkt_open) begin
			// Outside a packet only the opening byte matters.
			if (c == fppjg_pkg::CH_OPEN) begin
				pkt_open = 1'b1;
				clear_number();
			end
			return;
		end
		if (c != fppjg_pkg::CH_CLOSE) begin
			if (c == fppjg_pkg::CH_SEP) begin
				if (sep_seen < 2'd2)
					sep_seen++;
			end else if (sep_seen == 2'd1) begin
				decode_char(c);
			end
			return;
		end

		// Closing byte: gate the value against the held position.
		if (num_neg)
			val = -num_mag;
		else if (num_mag > int'(fppjg_pkg::POS_MAX))
			val = int'(fppjg_pkg::POS_MAX);
		else
			val = num_mag;
		gap = val - int'(held_pos);
		if (gap < 0)
			gap = -gap;
		ok = (gap < int'(jump_lim));
		if (ok)
			held_pos = fppjg_pkg::pos_t'(val);
		pkt_open = 1'b0;
		clear_number();

		// Window of 2h LEDs around the held position, clipped to the strip.
		h     = int'(halo);
		first = int'(held_pos) - h;
		last  = int'(held_pos) + h - 1;
		if (first < 0)
			first = 0;
		if (last > STRIP - 1)
			last = STRIP - 1;
		r.empty = (h == 0) || (first > last);
		if (r.empty) begin
			first = 0;
			last  = 0;
		end
		r.position = held_pos;
		r.accepted = ok;
		r.first    = fppjg_pkg::led_idx_t'(first);
		r.last     = fppjg_pkg::led_idx_t'(last);
		reports_due.push_back(r);
		if (ok)
			accept_count++;
	endtask

	// ------------------------------------------------------------------
	// Byte sender. Inputs change on the falling edge; an item is taken at
	// the rising edge where valid and ready are both high. Valid stays high
	// from one item to the next unless a random gap is drawn.
	// ------------------------------------------------------------------
	task automatic send_byte(input fppjg_pkg::byte_t c);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 21) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= c;
		@(posedge clk);
		while (!rx_ch.ready) begin
			rx_stall_cycs++;
			@(posedge clk);
		end
		track_byte(c);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(fppjg_pkg::byte_t'(s[i]));
	endtask

	// Stop sending and let every owed result come out, then let the
	// pipeline run on with idle inputs, so that a register write cannot overtake
	// a byte that is still in flight.
	task automatic settle();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_register(input fppjg_pkg::cfg_idx_t idx,
		input fppjg_pkg::cfg_data_t value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		if (idx == fppjg_pkg::REG_JUMP_LIMIT)
			jump_lim = fppjg_pkg::limit_t'(value);
		else if (idx == fppjg_pkg::REG_HALO_HALF)
			halo = fppjg_pkg::halo_t'(value[fppjg_pkg::HALO_W-1:0]);
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls, plus a long hold-off on request that is
	// counted here in cycles. The checker compares each taken result item
	// with the oldest expectation, field by field.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int stall;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= !(gaps_on && $urandom_range(99) < 21);
		end
	end

	task automatic flag_mismatch(input string field, input int want, input int got);
		errors++;
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		window_report_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (reports_due.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: expected none, actual position %0d",
					$time, res_ch.position);
			end else begin
				want = reports_due.pop_front();
				reports_seen++;
				if (res_ch.position !== want.position)
					flag_mismatch("position", int'(want.position),
						int'(res_ch.position));
				if (res_ch.accepted !== want.accepted)
					flag_mismatch("accepted", int'(want.accepted),
						int'(res_ch.accepted));
				if (res_ch.window_first !== want.first)
					flag_mismatch("window_first", int'(want.first),
						int'(res_ch.window_first));
				if (res_ch.window_last !== want.last)
					flag_mismatch("window_last", int'(want.last),
						int'(res_ch.window_last));
				if (res_ch.window_empty !== want.empty)
					flag_mismatch("window_empty", int'(want.empty),
						int'(res_ch.window_empty));
			end
		end
	end

	// ------------------------------------------------------------------
	// Random packet content.
	// ------------------------------------------------------------------
	// Any byte that neither separates fields nor closes the packet.
	function automatic fppjg_pkg::byte_t field_char();
		fppjg_pkg::byte_t c;
		do
			c = fppjg_pkg::byte_t'($urandom);
		while (c == fppjg_pkg::CH_SEP || c == fppjg_pkg::CH_CLOSE);
		return c;
	endfunction

	// Space or one of tab, line feed, vertical tab, form feed, return.
	function automatic fppjg_pkg::byte_t blank_char();
		if ($urandom_range(5) == 0)
			return fppjg_pkg::CH_SPACE;
		return fppjg_pkg::CH_TAB + fppjg_pkg::byte_t'($urandom_range(0,
			fppjg_pkg::CH_CR - fppjg_pkg::CH_TAB));
	endfunction

	// Most items are well-formed packets whose value lands near the held
	// position, so the gate both passes and rejects often. The rest carry
	// wider values, long or no digits, or are noise bursts, packets without a
	// separator and packets with one byte overwritten at random.
	task automatic send_random_packet();
		fppjg_pkg::byte_t pkt[$];
		string digits;
		int kind, mode, val, span;
		logic sign_from_val;
		kind = $urandom_range(99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 6)) pkt.push_back(fppjg_pkg::byte_t'($urandom));
		end else begin
			pkt.push_back(fppjg_pkg::CH_OPEN);
			repeat ($urandom_range(0, 3)) pkt.push_back(field_char());
			if (kind >= 13) begin
				pkt.push_back(fppjg_pkg::CH_SEP);
				repeat ($urandom_range(0, 2)) pkt.push_back(blank_char());
				mode = $urandom_range(9);
				span = (jump_lim > 300) ? 600 : 2 * int'(jump_lim) + 2;
				sign_from_val = 1'b1;
				digits = "";
				case (mode)
				0, 1, 2, 3, 4, 5: begin
					val = int'(held_pos) + int'($urandom_range(0, 2 * span)) - span;
				end
				6: begin
					val = int'($urandom_range(0, 200));
				end
				9: begin
					val = int'($urandom_range(0, 65535)) - 32768;
				end
				default: begin
					// Long digit strings that often overflow, or no digits at all.
					sign_from_val = 1'b0;
					val = 0;
					if (mode == 7)
						repeat ($urandom_range(5, 9))
							digits = {digits, $sformatf("%0d", $urandom_range(9))};
				end
				endcase
				if (sign_from_val) begin
					if (val < 0)
						pkt.push_back(fppjg_pkg::CH_MINUS);
					else if ($urandom_range(3) == 0)
						pkt.push_back(fppjg_pkg::CH_PLUS);
					digits = $sformatf("%0d", (val < 0) ? -val : val);
				end else begin
					case ($urandom_range(3))
					0: pkt.push_back(fppjg_pkg::CH_MINUS);
					1: pkt.push_back(fppjg_pkg::CH_PLUS);
					default: ;
					endcase
				end
				for (int i = 0; i < digits.len(); i++)
					pkt.push_back(fppjg_pkg::byte_t'(digits[i]));
				if ($urandom_range(3) == 0)
					pkt.push_back(field_char());
				if ($urandom_range(3) == 0) begin
					pkt.push_back(fppjg_pkg::CH_SEP);
					repeat ($urandom_range(0, 3)) pkt.push_back(field_char());
				end
				if (kind >= 95)
					pkt[$urandom_range(1, pkt.size() - 1)] = fppjg_pkg::byte_t'($urandom);
			end
			pkt.push_back(fppjg_pkg::CH_CLOSE);
		end
		foreach (pkt[i])
			send_byte(pkt[i]);
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------
	// Reset settings: a close byte outside a packet, a value that
	// passes the gate and pulls the window against strip start, a value
	// that overflows and is rejected, a packet without a separator, a
	// packet whose field starts with 's', and whitespace with a plus sign.
	task automatic test_directed_packets();
		send_text("es;-14e");
		send_text("s;99999e");
		send_text("se");
		send_text("s;s7e");
		send_text("s; \t+3;9e");
		settle();
	endtask

	// Register extremes: a zero jump limit rejects even an equal value, the
	// widest limit lets the position swing to the bottom of the range, a
	// zero halo gives an empty window, the widest halo and a halo near the
	// strip end show both clipping edges, and a write to an unused index
	// changes nothing.
	task automatic test_register_extremes();
		write_register(fppjg_pkg::REG_JUMP_LIMIT, 16'd0);
		send_text("s;3e");
		send_text("s;-3e");
		settle();
		write_register(fppjg_pkg::REG_JUMP_LIMIT, 16'hFFFF);
		write_register(fppjg_pkg::REG_HALO_HALF, 16'd0);
		send_text("s;-32768e");
		send_text("s;77e");
		settle();
		write_register(fppjg_pkg::REG_HALO_HALF, {8'hA5, 8'hFF});
		write_register(REG_UNUSED, 16'h5A5A);
		send_text("s;149e");
		send_text("s;300e");
		send_text("s;500e");
		send_text("s;-200e");
		send_text("s;32767e");
		settle();
		write_register(fppjg_pkg::REG_HALO_HALF, {8'h00, fppjg_pkg::HALO_HALF_RST});
		send_text("s;149e");
		send_text("s;140e");
		settle();
		write_register(fppjg_pkg::REG_JUMP_LIMIT, {8'h00, 8'd40});
	endtask

	// The receiver holds off for a long stretch while short packets keep
	// coming back to back, so the pipeline fills and the byte input stalls.
	// Then every result drains and random packets run under a shorter hold-off.
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_request = 80;
		repeat (30)
			send_text($sformatf("s;%0de", $urandom_range(0, 60)));
		gaps_on = 1'b1;
		settle();
		hold_request = 40;
		repeat (20) send_random_packet();
		settle();
	endtask

	// Random traffic in phases, each with its own register settings; one
	// phase runs with no idling on either side.
	task automatic test_random_traffic();
		int goal, phase;
		fppjg_pkg::cfg_data_t lim_val;
		fppjg_pkg::halo_t halo_val;
		goal  = live_bytes + 1150;
		phase = 0;
		while (live_bytes < goal) begin
			settle();
			case ($urandom_range(5))
			0: lim_val = 16'd0;
			1: lim_val = 16'hFFFF;
			2: lim_val = {8'h00, 8'd40};
			3: lim_val = fppjg_pkg::cfg_data_t'($urandom);
			default: lim_val = fppjg_pkg::cfg_data_t'($urandom_range(1, 300));
			endcase
			case ($urandom_range(5))
			0: halo_val = '0;
			1: halo_val = '1;
			2: halo_val = fppjg_pkg::HALO_HALF_RST;
			3: halo_val = fppjg_pkg::halo_t'($urandom);
			default: halo_val = fppjg_pkg::halo_t'($urandom_range(1, 80));
			endcase
			write_register(fppjg_pkg::REG_JUMP_LIMIT, lim_val);
			write_register(fppjg_pkg::REG_HALO_HALF, {8'(($urandom)), halo_val});
			gaps_on = (phase != 2);
			repeat ($urandom_range(15, 40)) send_random_packet();
			phase++;
		end
		gaps_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = '0;
		cfg_ch.data   = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_packets();
		test_register_extremes();
		test_backpressure();
		test_random_traffic();

		// Drain what is left, bounded, then let the block run quiet.
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		for (int n = 0; n < 5000 && reports_due.size() != 0; n++)
			@(posedge clk);
		repeat (LATENCY + 6) @(posedge clk);
		if (reports_due.size() != 0) begin
			errors += reports_due.size();
			$display("%0t: %0d results never arrived: expected %0d more, actual 0",
				$time, reports_due.size(), reports_due.size());
		end

		$display("Run covered %0d packet bytes and %0d register writes; %0d results checked,",
			live_bytes, reg_writes, reports_seen);
		$display("%0d of them accepted, with %0d cycles of stalled byte input.",
			accept_count, rx_stall_cycs);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[framed_position_parser_with_jump_gate.f]
src/fppjg_pkg.sv
src/fppjg_if.sv
src/framed_position_parser_with_jump_gate.sv
test/testbench.sv
